// ===== src/wnss_pkg.sv =====
package wnss_pkg;

    localparam int MAX_NODES = 1024;
    localparam int IDX_W     = $clog2(MAX_NODES);
    localparam int CNT_W     = $clog2(MAX_NODES + 1);
    localparam int SUM_W     = 34;
    localparam int AXES      = 4;
    localparam int FIELD_W   = 16;
    localparam int NODE_W    = AXES * FIELD_W;

    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_QUERY  = 2'd1;
    localparam logic [1:0] MODE_CLEAR  = 2'd2;

    localparam logic [1:0] REG_X_WEIGHT   = 2'd0;
    localparam logic [1:0] REG_Y_WEIGHT   = 2'd1;
    localparam logic [1:0] REG_YAW_WEIGHT = 2'd2;
    localparam logic [1:0] REG_VEL_WEIGHT = 2'd3;

    localparam logic [1:0] AXIS_YAW = 2'd2;

    localparam logic [15:0] X_WEIGHT_RST   = 16'd256;
    localparam logic [15:0] Y_WEIGHT_RST   = 16'd512;
    localparam logic [15:0] YAW_WEIGHT_RST = 16'd20861;
    localparam logic [15:0] VEL_WEIGHT_RST = 16'd6554;

    typedef struct packed {
        logic [1:0]         mode;
        logic signed [15:0] state_x;
        logic signed [15:0] state_y;
        logic signed [15:0] state_yaw;
        logic signed [15:0] state_vel;
    } in_item_t;

    typedef struct packed {
        logic [9:0]  node_index;
        logic [35:0] sq_distance;
        logic        found;
        logic        store_full;
    } out_item_t;

    // one node on its way down the cell chain; node packed {vel, yaw, y, x}
    typedef struct packed {
        logic              valid;
        logic              last;
        logic [IDX_W-1:0]  idx;
        logic [NODE_W-1:0] node;
        logic [SUM_W-1:0]  sum;
    } beat_t;

endpackage

// ===== src/wnss_cell.sv =====
module wnss_cell (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [1:0]                 sel,
    input  logic [wnss_pkg::NODE_W-1:0] sample,
    input  logic [15:0]                weight,
    input  wnss_pkg::beat_t            beat_in,
    output wnss_pkg::beat_t            beat_out
);

    wnss_pkg::beat_t  s1_reg;
    logic [31:0]      prod_reg;
    wnss_pkg::beat_t  s2_reg;
    wnss_pkg::beat_t  s2_next;

    logic signed [16:0] diff;
    logic [15:0]        abs_diff;
    logic [31:0]        prod_next;
    logic [15:0]        norm;
    logic [31:0]        sq;
    logic [15:0]        node_f;
    logic [15:0]        samp_f;

    always_comb
    begin
        node_f    = beat_in.node[sel*wnss_pkg::FIELD_W +: wnss_pkg::FIELD_W];
        samp_f    = sample[sel*wnss_pkg::FIELD_W +: wnss_pkg::FIELD_W];
        diff      = {node_f[15], node_f} - {samp_f[15], samp_f};
        abs_diff  = diff[16] ? 16'(-diff) : diff[15:0];
        prod_next = 32'(abs_diff) * 32'(weight);
        // yaw is Q3.13, so drop five more bits to land on Q8.8
        norm      = (sel == wnss_pkg::AXIS_YAW) ? 16'(prod_reg >> 21) : prod_reg[31:16];
        sq        = 32'(norm) * 32'(norm);
        s2_next     = s1_reg;
        s2_next.sum = s1_reg.sum + wnss_pkg::SUM_W'(sq);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg   <= '0;
            prod_reg <= '0;
            s2_reg   <= '0;
        end
        else
        begin
            s1_reg   <= beat_in;
            prod_reg <= prod_next;
            s2_reg   <= s2_next;
        end
    end

    assign beat_out = s2_reg;

endmodule

// ===== src/weighted_nearest_state_search.sv =====
// Weighted nearest-state search over a store of up to 1024 node states.
// Command channel: item is taken at a clock edge with start high and busy low.
// Result channel: result is valid for exactly one cycle when result_valid is
// high; the receiver cannot stall it, so it must take it in that cycle.
// Insert (mode 0) and clear (mode 2) and mode 3 return their result in the
// cycle after the command and never raise busy; a new command may follow at
// once. Query (mode 1) raises busy while it streams every stored node out of
// the node memory, one per cycle, into a chain of four axis cells (two stages
// each) and a running minimum. An empty store answers in the next cycle.
// The scan reads the stored nodes over the single memory read port.
// Config: cfg_we writes cfg_data[15:0] into weight register cfg_index at the
// clock edge; write only while idle.
// Reset empties the store (fill count to zero) and loads the default weights;
// no clearing pass is run, entries at or above the fill count are never read.
module weighted_nearest_state_search (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  wnss_pkg::in_item_t   item,
    output logic                 busy,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_index,
    input  logic [15:0]          cfg_data,
    output logic                 result_valid,
    output wnss_pkg::out_item_t  result
);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SCAN  = 3'b010,
        ST_DRAIN = 3'b100
    } state_t;

    state_t state_reg, state_next;

    logic [wnss_pkg::CNT_W-1:0]  count_reg;
    logic [wnss_pkg::IDX_W-1:0]  rd_addr_reg;
    logic                        rd_valid_reg;
    logic                        rd_last_reg;
    logic [wnss_pkg::IDX_W-1:0]  rd_idx_reg;
    logic [wnss_pkg::NODE_W-1:0] rd_data_reg;
    logic [wnss_pkg::NODE_W-1:0] sample_reg;
    logic [15:0]                 weight_reg [wnss_pkg::AXES];
    logic                        have_reg;
    logic [wnss_pkg::SUM_W-1:0]  best_d_reg;
    logic [wnss_pkg::IDX_W-1:0]  best_idx_reg;
    logic                        result_valid_reg;
    wnss_pkg::out_item_t         result_reg;
    wnss_pkg::out_item_t         result_next;

    logic [wnss_pkg::NODE_W-1:0] node_mem [wnss_pkg::MAX_NODES];

    wnss_pkg::beat_t chain [wnss_pkg::AXES+1];

    logic                        accept;
    logic [wnss_pkg::NODE_W-1:0] item_node;
    logic                        do_insert;
    logic                        last_addr;
    logic                        better;
    logic [wnss_pkg::SUM_W-1:0]  fin_d;
    logic [wnss_pkg::IDX_W-1:0]  fin_idx;
    wnss_pkg::beat_t             tail;

    assign busy         = (state_reg != ST_IDLE);
    assign accept       = start && !busy;
    assign item_node    = {item.state_vel, item.state_yaw, item.state_y, item.state_x};
    assign do_insert    = accept && (item.mode == wnss_pkg::MODE_INSERT)
                          && (count_reg < wnss_pkg::CNT_W'(wnss_pkg::MAX_NODES));
    assign last_addr    = (wnss_pkg::CNT_W'(rd_addr_reg) + 1'b1) == count_reg;
    assign tail         = chain[wnss_pkg::AXES];
    assign better       = !have_reg || (tail.sum < best_d_reg);
    assign fin_d        = better ? tail.sum : best_d_reg;
    assign fin_idx      = better ? tail.idx : best_idx_reg;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (accept && item.mode == wnss_pkg::MODE_QUERY && count_reg != '0)
                    state_next = ST_SCAN;
            ST_SCAN:
                if (last_addr)
                    state_next = ST_DRAIN;
            ST_DRAIN:
                if (tail.valid && tail.last)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        result_next = result_reg;
        if (accept)
        begin
            result_next = '0;
            if (do_insert)
            begin
                result_next.node_index = 10'(count_reg);
                result_next.found      = 1'b1;
            end
            else if (item.mode == wnss_pkg::MODE_INSERT)
                result_next.store_full = 1'b1;
        end
        if (state_reg == ST_DRAIN && tail.valid && tail.last)
        begin
            result_next.node_index  = 10'(fin_idx);
            result_next.sq_distance = 36'(fin_d);
            result_next.found       = 1'b1;
            result_next.store_full  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            count_reg        <= '0;
            rd_addr_reg      <= '0;
            rd_valid_reg     <= 1'b0;
            rd_last_reg      <= 1'b0;
            have_reg         <= 1'b0;
            result_valid_reg <= 1'b0;
            weight_reg[0]    <= wnss_pkg::X_WEIGHT_RST;
            weight_reg[1]    <= wnss_pkg::Y_WEIGHT_RST;
            weight_reg[2]    <= wnss_pkg::YAW_WEIGHT_RST;
            weight_reg[3]    <= wnss_pkg::VEL_WEIGHT_RST;
        end
        else
        begin
            state_reg        <= state_next;
            // a query over a non-empty store answers at the end of the scan
            result_valid_reg <= (accept && !(item.mode == wnss_pkg::MODE_QUERY
                                             && count_reg != '0))
                                || (state_reg == ST_DRAIN && tail.valid && tail.last);
            rd_valid_reg     <= (state_reg == ST_SCAN);
            rd_last_reg      <= (state_reg == ST_SCAN) && last_addr;
            have_reg         <= accept ? 1'b0 : (have_reg || tail.valid);

            if (cfg_we)
            begin
                case (cfg_index)
                    wnss_pkg::REG_X_WEIGHT:   weight_reg[0] <= cfg_data;
                    wnss_pkg::REG_Y_WEIGHT:   weight_reg[1] <= cfg_data;
                    wnss_pkg::REG_YAW_WEIGHT: weight_reg[2] <= cfg_data;
                    wnss_pkg::REG_VEL_WEIGHT: weight_reg[3] <= cfg_data;
                    default: ;
                endcase
            end

            if (accept)
            begin
                if (do_insert)
                    count_reg <= count_reg + 1'b1;
                if (item.mode == wnss_pkg::MODE_CLEAR)
                    count_reg <= '0;
                rd_addr_reg <= '0;
            end

            if (state_reg == ST_SCAN)
                rd_addr_reg <= rd_addr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_insert)
            node_mem[count_reg[wnss_pkg::IDX_W-1:0]] <= item_node;
        rd_data_reg <= node_mem[rd_addr_reg];
        rd_idx_reg  <= rd_addr_reg;

        if (accept)
            sample_reg <= item_node;

        result_reg <= result_next;

        if (tail.valid)
        begin
            best_d_reg   <= fin_d;
            best_idx_reg <= fin_idx;
        end
    end

    always_comb
    begin
        chain[0].valid = rd_valid_reg;
        chain[0].last  = rd_last_reg;
        chain[0].idx   = rd_idx_reg;
        chain[0].node  = rd_data_reg;
        chain[0].sum   = '0;
    end

    for (genvar k = 0; k < wnss_pkg::AXES; k++)
    begin : g_cell
        wnss_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .sel      (2'(k)),
            .sample   (sample_reg),
            .weight   (weight_reg[k]),
            .beat_in  (chain[k]),
            .beat_out (chain[k+1])
        );
    end

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !(result.found && result.store_full))
        else $error("found and store_full both set");

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (wnss_pkg::CNT_W'(rd_addr_reg) < count_reg))
        else $error("scan address beyond fill count");

    a_last_answers: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DRAIN && tail.valid && tail.last) |=> (result_valid && !busy))
        else $error("query end produced no result");

    a_busy_no_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |=> !result_valid)
        else $error("result strobe during scan");

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

    localparam logic [1:0] MODE_IGNORED = 2'd3;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    wnss_pkg::in_item_t   item;
    logic                 busy;
    logic                 cfg_we;
    logic [1:0]           cfg_index;
    logic [15:0]          cfg_data;
    logic                 result_valid;
    wnss_pkg::out_item_t  result;

    weighted_nearest_state_search i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .item         (item),
        .busy         (busy),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .result       (result)
    );

    // shadow copy of the node store, fill count and weight registers
    logic [15:0] shadow_nodes [wnss_pkg::MAX_NODES][wnss_pkg::AXES];
    int          shadow_count;
    logic [15:0] weight_regs [wnss_pkg::AXES];

    wnss_pkg::out_item_t pending_results [$];
    int                  mismatch_count;
    bit                  run_failed;
    bit                  gaps_on;

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    initial
    begin
        #20ms;
        $display("FAILURE");
        $finish;
    end

    function automatic logic [33:0] axis_term(logic [15:0] a, logic [15:0] b,
                                             logic [15:0] w, bit yaw_axis);
        logic signed [16:0] diff;
        logic [16:0]        mag;
        logic [31:0]        prod;
        logic [15:0]        norm;
        logic [33:0]        sq;
        diff = $signed({a[15], a}) - $signed({b[15], b});
        mag  = diff[16] ? -diff : diff;
        prod = 32'(mag[15:0]) * 32'(w);
        norm = yaw_axis ? 16'(prod >> 21) : 16'(prod >> 16);
        sq   = 34'(norm) * 34'(norm);
        return sq;
    endfunction

    // apply one command to the shadow state and return the result it should give
    function automatic wnss_pkg::out_item_t predict_search(wnss_pkg::in_item_t it);
        wnss_pkg::out_item_t res;
        logic [15:0]         s [wnss_pkg::AXES];
        logic [33:0]         cand_d;
        logic [33:0]         near_d;
        int                  best;
        res = '0;
        s[0] = it.state_x;
        s[1] = it.state_y;
        s[2] = it.state_yaw;
        s[3] = it.state_vel;
        case (it.mode)
            wnss_pkg::MODE_INSERT:
            begin
                if (shadow_count < wnss_pkg::MAX_NODES)
                begin
                    for (int a = 0; a < wnss_pkg::AXES; a++)
                        shadow_nodes[shadow_count][a] = s[a];
                    res.node_index = shadow_count[9:0];
                    res.found      = 1'b1;
                    shadow_count++;
                end
                else
                    res.store_full = 1'b1;
            end
            wnss_pkg::MODE_QUERY:
            begin
                best   = -1;
                near_d = '0;
                for (int i = 0; i < shadow_count; i++)
                begin
                    cand_d = '0;
                    for (int a = 0; a < wnss_pkg::AXES; a++)
                        cand_d += axis_term(shadow_nodes[i][a], s[a], weight_regs[a],
                                            a == wnss_pkg::AXIS_YAW);
                    if (best < 0 || cand_d < near_d)
                    begin
                        best   = i;
                        near_d = cand_d;
                    end
                end
                if (best >= 0)
                begin
                    res.node_index  = best[9:0];
                    res.sq_distance = {2'b00, near_d};
                    res.found       = 1'b1;
                end
            end
            wnss_pkg::MODE_CLEAR:
                shadow_count = 0;
            default: ;
        endcase
        return res;
    endfunction

    // result checker
    always @(posedge clk)
    begin
        wnss_pkg::out_item_t want;
        if (rst_n && result_valid)
        begin
            if (pending_results.size() == 0)
            begin
                run_failed = 1'b1;
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result beat: %p", result);
            end
            else
            begin
                want = pending_results.pop_front();
                if (result.node_index !== want.node_index
                    || result.sq_distance !== want.sq_distance
                    || result.found !== want.found
                    || result.store_full !== want.store_full)
                begin
                    run_failed = 1'b1;
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"mismatch: expected idx %0d dist %0d found %0b full %0b,",
                                  " got idx %0d dist %0d found %0b full %0b"},
                                 want.node_index, want.sq_distance, want.found,
                                 want.store_full, result.node_index, result.sq_distance,
                                 result.found, result.store_full);
                end
            end
        end
    end

    // called at a falling edge; returns at a falling edge with start still high unless a random gap dropped it
    task automatic send_command(logic [1:0] mode, logic [15:0] x, logic [15:0] y,
                                logic [15:0] yaw, logic [15:0] vel);
        wnss_pkg::in_item_t it;
        it.mode      = mode;
        it.state_x   = x;
        it.state_y   = y;
        it.state_yaw = yaw;
        it.state_vel = vel;
        item  = it;
        start = 1'b1;
        forever
        begin
            @(posedge clk);
            if (!busy)
                break;
        end
        pending_results.insert(pending_results.size(), predict_search(it));
        @(negedge clk);
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            start = 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge clk);
        end
    endtask

    task automatic send_random_state(logic [1:0] mode);
        send_command(mode, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    endtask

    // hold until every expected beat has arrived and the scan pipe is empty
    task automatic drain_results();
        start = 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (16) @(negedge clk);
    endtask

    task automatic write_weight(logic [1:0] idx, logic [15:0] value);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        weight_regs[idx] = value;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic load_weights(logic [15:0] wx, logic [15:0] wy, logic [15:0] wyaw,
                                logic [15:0] wvel);
        drain_results();
        write_weight(wnss_pkg::REG_X_WEIGHT, wx);
        write_weight(wnss_pkg::REG_Y_WEIGHT, wy);
        write_weight(wnss_pkg::REG_YAW_WEIGHT, wyaw);
        write_weight(wnss_pkg::REG_VEL_WEIGHT, wvel);
    endtask

    task automatic test_directed();
        send_random_state(wnss_pkg::MODE_QUERY);          // empty store on the first call
        send_command(wnss_pkg::MODE_INSERT, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
        send_command(wnss_pkg::MODE_INSERT, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
        send_command(wnss_pkg::MODE_INSERT, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_command(wnss_pkg::MODE_INSERT, 16'h0000, 16'h0000, 16'h0000, 16'h0000);  // tie
        send_command(wnss_pkg::MODE_QUERY, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
        send_command(wnss_pkg::MODE_QUERY, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
        send_command(wnss_pkg::MODE_QUERY, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_command(wnss_pkg::MODE_QUERY, 16'hffff, 16'h0001, 16'hffff, 16'h0001);
        send_random_state(MODE_IGNORED);
        send_random_state(wnss_pkg::MODE_QUERY);
        send_random_state(wnss_pkg::MODE_CLEAR);
        send_random_state(wnss_pkg::MODE_QUERY);
        send_random_state(wnss_pkg::MODE_INSERT);
        send_random_state(wnss_pkg::MODE_QUERY);
    endtask

    task automatic test_weight_extremes();
        load_weights(16'hffff, 16'hffff, 16'hffff, 16'hffff);
        test_directed();
        load_weights(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_random_state(wnss_pkg::MODE_INSERT);
        send_random_state(wnss_pkg::MODE_INSERT);
        send_random_state(wnss_pkg::MODE_QUERY);          // every distance zero
    endtask

    task automatic test_random_traffic(int count);
        int pick;
        int n;
        for (int k = 0; k < count; k++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
                send_random_state(wnss_pkg::MODE_INSERT);
            else if (pick < 85)
            begin
                // often probe close to a stored node so near misses and ties come up
                if (shadow_count > 0 && $urandom_range(0, 1) == 1)
                begin
                    n = $urandom_range(0, shadow_count - 1);
                    send_command(wnss_pkg::MODE_QUERY,
                                 16'(shadow_nodes[n][0] + $urandom_range(0, 600) - 300),
                                 16'(shadow_nodes[n][1] + $urandom_range(0, 600) - 300),
                                 16'(shadow_nodes[n][2] + $urandom_range(0, 600) - 300),
                                 16'(shadow_nodes[n][3] + $urandom_range(0, 600) - 300));
                end
                else
                    send_random_state(wnss_pkg::MODE_QUERY);
            end
            else if (pick < 88 && shadow_count > 0)
            begin
                n = $urandom_range(0, shadow_count - 1);
                send_command(wnss_pkg::MODE_INSERT, shadow_nodes[n][0], shadow_nodes[n][1],
                             shadow_nodes[n][2], shadow_nodes[n][3]);
            end
            else if (pick < 95)
                send_random_state(wnss_pkg::MODE_CLEAR);
            else
                send_random_state(MODE_IGNORED);
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        start     = 1'b0;
        item      = '0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        gaps_on   = 1'b1;
        mismatch_count = 0;
        run_failed     = 1'b0;
        shadow_count   = 0;
        weight_regs[0] = wnss_pkg::X_WEIGHT_RST;
        weight_regs[1] = wnss_pkg::Y_WEIGHT_RST;
        weight_regs[2] = wnss_pkg::YAW_WEIGHT_RST;
        weight_regs[3] = wnss_pkg::VEL_WEIGHT_RST;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_weight_extremes();
        load_weights(wnss_pkg::X_WEIGHT_RST, wnss_pkg::Y_WEIGHT_RST,
                     wnss_pkg::YAW_WEIGHT_RST, wnss_pkg::VEL_WEIGHT_RST);
        test_random_traffic(160);
        load_weights(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        test_random_traffic(160);
        load_weights(16'($urandom), 16'hffff, 16'($urandom), 16'h0000);
        test_random_traffic(110);
        gaps_on = 1'b0;
        test_random_traffic(100);

        drain_results();
        repeat (40) @(negedge clk);
        if (!run_failed)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
